// ----- sv/cca_pkg.sv -----
package cca_pkg;

	// Fixed field widths
	localparam int TYPE_W    = 4;
	localparam int AGE_W     = 16;
	localparam int DRAW_W    = 16;
	localparam int FRAC_W    = 17;
	localparam int COUNT_W   = 5;
	localparam int KIND_W    = 3;
	localparam int NB_PORTS  = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 17;

	// Largest neighbor count the lanes support, and the tally width it needs
	localparam int MAX_NEIGHBORS = 8;
	localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);

	// Types at or above this limit are never counted by the majority rule
	localparam int MAX_TYPES = 16;

	// Rule codes
	typedef enum logic [KIND_W-1:0] {
		RULE_NONE     = 3'd0,
		RULE_STRAIGHT = 3'd1,
		RULE_TRIGGER  = 3'd2,
		RULE_MAJORITY = 3'd3,
		RULE_PROB     = 3'd4
	} rule_kind_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RULE_KIND   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_TYPE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TYPE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ALT_TYPE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AGE_THRESH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STATE_COUNT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SUCCESS     = 3'd6;

	typedef struct packed {
		logic [TYPE_W-1:0]   center_type;
		logic [AGE_W-1:0]    center_age;
		logic [TYPE_W-1:0]   neighbor_type_0;
		logic [TYPE_W-1:0]   neighbor_type_1;
		logic [TYPE_W-1:0]   neighbor_type_2;
		logic [TYPE_W-1:0]   neighbor_type_3;
		logic [TYPE_W-1:0]   neighbor_type_4;
		logic [TYPE_W-1:0]   neighbor_type_5;
		logic [TYPE_W-1:0]   neighbor_type_6;
		logic [TYPE_W-1:0]   neighbor_type_7;
		logic [NB_PORTS-1:0] neighbor_valid;
		logic [DRAW_W-1:0]   random_draw;
	} cell_in_t;

	typedef struct packed {
		logic [TYPE_W-1:0] next_type;
		logic              no_rule;
	} cell_out_t;

	// What one lane found about its neighbor
	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] cnt;
	} lane_res_t;

	// Per-cell facts that travel beside the lane results
	typedef struct packed {
		logic [TYPE_W-1:0] center;
		logic              src_eq;
		logic              timed;
		logic              draw_lt;
	} cell_ctx_t;

	// Rule settings the merge stage needs
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TYPE_W-1:0] target;
		logic [TYPE_W-1:0] alternate;
	} rule_cfg_t;

endpackage

// ----- sv/cca_lane.sv -----
module cca_lane #(
	parameter int NumNeighbors = cca_pkg::MAX_NEIGHBORS,
	parameter int Idx          = 0
) (
	input  logic [NumNeighbors-1:0][cca_pkg::TYPE_W-1:0] types,
	input  logic [NumNeighbors-1:0]                      elig,
	input  logic [NumNeighbors-1:0]                      valid,
	input  logic [cca_pkg::TYPE_W-1:0]                   target,
	output cca_pkg::lane_res_t                           res
);

	// Count eligible neighbors up to this one that share its type; flag a trigger match
	always_comb begin
		logic [cca_pkg::CNT_W-1:0] cnt;
		cnt = '0;
		for (int j = 0; j <= Idx; j++) begin
			if (elig[j] && (types[j] == types[Idx])) begin
				cnt = cnt + cca_pkg::CNT_W'(1);
			end
		end
		res.cnt = cnt;
		res.hit = valid[Idx] && (types[Idx] == target);
	end

endmodule

// ----- sv/cca_merge.sv -----
module cca_merge #(
	parameter int NumNeighbors = cca_pkg::MAX_NEIGHBORS
) (
	input  cca_pkg::lane_res_t [NumNeighbors-1:0]        lanes,
	input  logic [NumNeighbors-1:0]                      elig,
	input  logic [NumNeighbors-1:0][cca_pkg::TYPE_W-1:0] types,
	input  cca_pkg::cell_ctx_t                           ctx,
	input  cca_pkg::rule_cfg_t                           cfg,
	output cca_pkg::cell_out_t                           res
);

	logic [cca_pkg::TYPE_W-1:0] leader;
	logic                       any_hit;

	// Replay the vote in neighbor order using each lane's running tally
	always_comb begin
		logic [cca_pkg::CNT_W-1:0] best;
		best   = '0;
		leader = '0;
		for (int i = 0; i < NumNeighbors; i++) begin
			if (elig[i]) begin
				if (lanes[i].cnt > best) begin
					best   = lanes[i].cnt;
					leader = types[i];
				end else if (lanes[i].cnt == best) begin
					leader = ctx.center;
				end
			end
		end
	end

	// Collect trigger matches
	always_comb begin
		any_hit = 1'b0;
		for (int i = 0; i < NumNeighbors; i++) begin
			any_hit = any_hit | lanes[i].hit;
		end
	end

	// Select the result for the configured rule
	always_comb begin
		res.no_rule   = 1'b0;
		res.next_type = ctx.center;
		case (cfg.kind)
			cca_pkg::RULE_STRAIGHT: begin
				if (ctx.timed) res.next_type = cfg.target;
			end
			cca_pkg::RULE_TRIGGER: begin
				if (ctx.src_eq && any_hit) res.next_type = cfg.target;
			end
			cca_pkg::RULE_MAJORITY: begin
				res.next_type = leader;
			end
			cca_pkg::RULE_PROB: begin
				if (ctx.timed) res.next_type = ctx.draw_lt ? cfg.target : cfg.alternate;
			end
			default: begin
				res.no_rule   = 1'b1;
				res.next_type = '0;
			end
		endcase
	end

endmodule

// ----- sv/cellular_automaton_cell_rule.sv -----
// Cell update rule for a cellular automaton grid engine.
// Configuration: write cfg_wdata to register cfg_addr while cfg_we is high;
// registers are rule kind, source, target and alternate types, age threshold,
// state count and success fraction. Write them only while no cell is in flight.
// Input: a cell (type, age, eight neighbor types, valid mask, random draw) is
// taken at each rising edge where start is high and busy is low. busy stays
// low, so a new cell may enter every cycle.
// Output: done pulses for one cycle with result (next type and no-rule flag);
// the receiver must take it then, there is no back-pressure.
// Throughput is one cell per cycle. Stage one has one lane per neighbor
// computing its running type tally and trigger match; stage two merges the
// lanes in neighbor order and selects the rule's result into the output
// register. Reset clears the pipeline valid bits and returns the registers
// to their defaults (no rule, state count 16).
module cellular_automaton_cell_rule #(
	parameter int NumNeighbors = cca_pkg::MAX_NEIGHBORS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [cca_pkg::CFG_IDX_W-1:0]     cfg_addr,
	input  logic [cca_pkg::CFG_DAT_W-1:0]     cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  cca_pkg::cell_in_t                 item,
	output logic                              done,
	output cca_pkg::cell_out_t                result
);

	localparam int TW = cca_pkg::TYPE_W;

	logic [cca_pkg::KIND_W-1:0]  rule_kind_q;
	logic [TW-1:0]               source_type_q;
	logic [TW-1:0]               target_type_q;
	logic [TW-1:0]               alternate_type_q;
	logic [cca_pkg::AGE_W-1:0]   age_threshold_q;
	logic [cca_pkg::COUNT_W-1:0] state_count_q;
	logic [cca_pkg::FRAC_W-1:0]  success_fraction_q;

	logic                                  accept;
	logic [cca_pkg::NB_PORTS-1:0][TW-1:0]  nb_all;
	logic [NumNeighbors-1:0][TW-1:0]       nb;
	logic [NumNeighbors-1:0]               nb_valid;
	logic [NumNeighbors-1:0]               elig;
	cca_pkg::lane_res_t [NumNeighbors-1:0] lanes;
	cca_pkg::cell_ctx_t                    ctx;
	cca_pkg::rule_cfg_t                    rule_cfg;
	cca_pkg::cell_out_t                    merged;

	logic                                  valid_s1;
	cca_pkg::lane_res_t [NumNeighbors-1:0] lanes_s1;
	logic [NumNeighbors-1:0]               elig_s1;
	logic [NumNeighbors-1:0][TW-1:0]       nb_s1;
	cca_pkg::cell_ctx_t                    ctx_s1;
	logic                                  done_q;
	cca_pkg::cell_out_t                    result_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_kind_q        <= cca_pkg::RULE_NONE;
			source_type_q      <= '0;
			target_type_q      <= '0;
			alternate_type_q   <= '0;
			age_threshold_q    <= '0;
			state_count_q      <= cca_pkg::COUNT_W'(16);
			success_fraction_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				cca_pkg::REG_RULE_KIND:   rule_kind_q        <= cfg_wdata[cca_pkg::KIND_W-1:0];
				cca_pkg::REG_SOURCE_TYPE: source_type_q      <= cfg_wdata[TW-1:0];
				cca_pkg::REG_TARGET_TYPE: target_type_q      <= cfg_wdata[TW-1:0];
				cca_pkg::REG_ALT_TYPE:    alternate_type_q   <= cfg_wdata[TW-1:0];
				cca_pkg::REG_AGE_THRESH:  age_threshold_q    <= cfg_wdata[cca_pkg::AGE_W-1:0];
				cca_pkg::REG_STATE_COUNT: state_count_q      <= cfg_wdata[cca_pkg::COUNT_W-1:0];
				cca_pkg::REG_SUCCESS:     success_fraction_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Gather neighbor types in order
	assign nb_all = {item.neighbor_type_7, item.neighbor_type_6, item.neighbor_type_5,
		item.neighbor_type_4, item.neighbor_type_3, item.neighbor_type_2,
		item.neighbor_type_1, item.neighbor_type_0};
	assign nb       = nb_all[NumNeighbors-1:0];
	assign nb_valid = item.neighbor_valid[NumNeighbors-1:0];

	// Mark neighbors the majority vote counts
	always_comb begin
		for (int i = 0; i < NumNeighbors; i++) begin
			elig[i] = nb_valid[i]
				&& ({1'b0, nb[i]} < state_count_q)
				&& (9'(nb[i]) < 9'(cca_pkg::MAX_TYPES));
		end
	end

	// One lane per neighbor
	for (genvar g = 0; g < NumNeighbors; g++) begin : g_lane
		cca_lane #(
			.NumNeighbors(NumNeighbors),
			.Idx(g)
		) u_lane (
			.types (nb),
			.elig  (elig),
			.valid (nb_valid),
			.target(target_type_q),
			.res   (lanes[g])
		);
	end

	// Per-cell comparisons for the straight, trigger and probabilistic rules, plus the center type
	always_comb begin
		ctx.center  = item.center_type;
		ctx.src_eq  = item.center_type == source_type_q;
		ctx.timed   = (item.center_type == source_type_q)
			&& (item.center_age >= age_threshold_q);
		ctx.draw_lt = {1'b0, item.random_draw} < success_fraction_q;
	end

	// Stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			lanes_s1 <= lanes;
			elig_s1  <= elig;
			nb_s1    <= nb;
			ctx_s1   <= ctx;
		end
	end

	assign rule_cfg.kind      = rule_kind_q;
	assign rule_cfg.target    = target_type_q;
	assign rule_cfg.alternate = alternate_type_q;

	cca_merge #(
		.NumNeighbors(NumNeighbors)
	) u_merge (
		.lanes(lanes_s1),
		.elig (elig_s1),
		.types(nb_s1),
		.ctx  (ctx_s1),
		.cfg  (rule_cfg),
		.res  (merged)
	);

	// Output strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// Hold the transaction result for its strobe cycle
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= merged;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import cca_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	// Rule codes past the defined ones; the block must flag them as no rule
	localparam logic [KIND_W-1:0] RULE_UNUSED_LO = 3'd5;
	localparam logic [KIND_W-1:0] RULE_UNUSED_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;
	logic start = 1'b0;
	logic busy;
	cell_in_t item = '0;
	logic done;
	cell_out_t result;

	// Shadow copy of the rule registers, at reset values
	logic [KIND_W-1:0]  cfg_kind = RULE_NONE;
	logic [TYPE_W-1:0]  cfg_source = '0;
	logic [TYPE_W-1:0]  cfg_target = '0;
	logic [TYPE_W-1:0]  cfg_alt = '0;
	logic [AGE_W-1:0]   cfg_thresh = '0;
	logic [COUNT_W-1:0] cfg_count = 5'd16;
	logic [FRAC_W-1:0]  cfg_frac = '0;

	cell_out_t pending_updates[$];
	cell_out_t oldest;
	int fails = 0;
	int cycles = 0;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [TYPE_W-1:0]  src;
		logic [TYPE_W-1:0]  tgt;
		logic [TYPE_W-1:0]  alt;
		logic [AGE_W-1:0]   thr;
		logic [COUNT_W-1:0] cnt;
		logic [FRAC_W-1:0]  frac;
		cell_in_t           stim;
		logic               fixed;
		cell_out_t          want;
	} dir_row_t;

	dir_row_t dir_rows[$];

	cellular_automaton_cell_rule dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Next cell type under the shadow rule settings
	function automatic cell_out_t rule_next_type(input cell_in_t c);
		logic [TYPE_W-1:0] nb [MAX_NEIGHBORS];
		logic [3:0] tally [MAX_TYPES];
		logic [3:0] best_cnt;
		logic [TYPE_W-1:0] best_ty;
		logic [COUNT_W-1:0] limit;
		logic timed;
		cell_out_t r;
		nb[0] = c.neighbor_type_0;
		nb[1] = c.neighbor_type_1;
		nb[2] = c.neighbor_type_2;
		nb[3] = c.neighbor_type_3;
		nb[4] = c.neighbor_type_4;
		nb[5] = c.neighbor_type_5;
		nb[6] = c.neighbor_type_6;
		nb[7] = c.neighbor_type_7;
		timed = (c.center_type == cfg_source) && (c.center_age >= cfg_thresh);
		r.no_rule = 1'b0;
		r.next_type = c.center_type;
		case (cfg_kind)
			RULE_STRAIGHT: begin
				if (timed)
					r.next_type = cfg_target;
			end
			RULE_TRIGGER: begin
				if (c.center_type == cfg_source)
					for (int i = 0; i < MAX_NEIGHBORS; i++)
						if (c.neighbor_valid[i] && nb[i] == cfg_target)
							r.next_type = cfg_target;
			end
			RULE_MAJORITY: begin
				// count in neighbor order; a tie with the running best hands it to the center
				limit = (cfg_count > MAX_TYPES) ? COUNT_W'(MAX_TYPES) : cfg_count;
				for (int t = 0; t < MAX_TYPES; t++)
					tally[t] = '0;
				best_cnt = '0;
				best_ty = '0;
				for (int i = 0; i < MAX_NEIGHBORS; i++) begin
					if (c.neighbor_valid[i] && {1'b0, nb[i]} < limit) begin
						tally[nb[i]] = tally[nb[i]] + 4'd1;
						if (tally[nb[i]] > best_cnt) begin
							best_cnt = tally[nb[i]];
							best_ty = nb[i];
						end else if (tally[nb[i]] == best_cnt) begin
							best_ty = c.center_type;
						end
					end
				end
				r.next_type = best_ty;
			end
			RULE_PROB: begin
				if (timed)
					r.next_type = ({1'b0, c.random_draw} < cfg_frac) ? cfg_target : cfg_alt;
			end
			default: begin
				r.no_rule = 1'b1;
				r.next_type = '0;
			end
		endcase
		return r;
	endfunction

	function automatic void add_row(input logic [KIND_W-1:0] kind, input logic [TYPE_W-1:0] src,
			input logic [TYPE_W-1:0] tgt, input logic [TYPE_W-1:0] alt,
			input logic [AGE_W-1:0] thr, input logic [COUNT_W-1:0] cnt,
			input logic [FRAC_W-1:0] frac, input cell_in_t stim, input logic fixed,
			input logic [TYPE_W-1:0] want_type, input logic want_flag);
		dir_row_t row;
		row.kind = kind;
		row.src = src;
		row.tgt = tgt;
		row.alt = alt;
		row.thr = thr;
		row.cnt = cnt;
		row.frac = frac;
		row.stim = stim;
		row.fixed = fixed;
		row.want.next_type = want_type;
		row.want.no_rule = want_flag;
		dir_rows.push_back(row);
	endfunction

	// Write one register; the shadow keeps only the register's own bits
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			REG_RULE_KIND:   cfg_kind = data[KIND_W-1:0];
			REG_SOURCE_TYPE: cfg_source = data[TYPE_W-1:0];
			REG_TARGET_TYPE: cfg_target = data[TYPE_W-1:0];
			REG_ALT_TYPE:    cfg_alt = data[TYPE_W-1:0];
			REG_AGE_THRESH:  cfg_thresh = data[AGE_W-1:0];
			REG_STATE_COUNT: cfg_count = data[COUNT_W-1:0];
			REG_SUCCESS:     cfg_frac = data[FRAC_W-1:0];
			default: ;
		endcase
	endtask

	// Hold off new cells until every result is back and the pipe is empty
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_updates.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Reprogram the rule; noisy writes every register with junk above its width
	task automatic set_rule(input logic [KIND_W-1:0] kind, input logic [TYPE_W-1:0] src,
			input logic [TYPE_W-1:0] tgt, input logic [TYPE_W-1:0] alt,
			input logic [AGE_W-1:0] thr, input logic [COUNT_W-1:0] cnt,
			input logic [FRAC_W-1:0] frac, input logic noisy);
		logic [CFG_DAT_W-1:0] junk;
		junk = noisy ? CFG_DAT_W'($urandom) : '0;
		if (noisy || kind != cfg_kind || src != cfg_source || tgt != cfg_target ||
				alt != cfg_alt || thr != cfg_thresh || cnt != cfg_count || frac != cfg_frac) begin
			drain();
			if (noisy || kind != cfg_kind)
				write_reg(REG_RULE_KIND, {junk[CFG_DAT_W-1:KIND_W], kind});
			if (noisy || src != cfg_source)
				write_reg(REG_SOURCE_TYPE, {junk[CFG_DAT_W-1:TYPE_W], src});
			if (noisy || tgt != cfg_target)
				write_reg(REG_TARGET_TYPE, {junk[CFG_DAT_W-1:TYPE_W], tgt});
			if (noisy || alt != cfg_alt)
				write_reg(REG_ALT_TYPE, {junk[CFG_DAT_W-1:TYPE_W], alt});
			if (noisy || thr != cfg_thresh)
				write_reg(REG_AGE_THRESH, {junk[CFG_DAT_W-1:AGE_W], thr});
			if (noisy || cnt != cfg_count)
				write_reg(REG_STATE_COUNT, {junk[CFG_DAT_W-1:COUNT_W], cnt});
			if (noisy || frac != cfg_frac)
				write_reg(REG_SUCCESS, frac);
			cfg_we <= 1'b0;
		end
	endtask

	// Offer one cell and record what it should turn into once it is taken
	task automatic send_cell(input cell_in_t c, input logic fixed, input cell_out_t want);
		start <= 1'b1;
		item <= c;
		do @(posedge clk); while (busy !== 1'b0);
		pending_updates.push_back(fixed ? want : rule_next_type(c));
	endtask

	// Drop start for a while: mostly short gaps, now and then a long one
	task automatic idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r >= 60) begin
			start <= 1'b0;
			repeat (r < 92 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
		end
	endtask

	// Check each result against the oldest pending transaction
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_updates.size() == 0) begin
				$error("result with no transaction pending: next_type=%0h no_rule=%0b",
					result.next_type, result.no_rule);
				fails++;
			end else begin
				oldest = pending_updates.pop_front();
				if (result.next_type !== oldest.next_type) begin
					$error("next_type: expected %0h, got %0h", oldest.next_type, result.next_type);
					fails++;
				end
				if (result.no_rule !== oldest.no_rule) begin
					$error("no_rule: expected %0b, got %0b", oldest.no_rule, result.no_rule);
					fails++;
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int a;
		int d;
		int r;
		logic [KIND_W-1:0] kind;
		logic [AGE_W-1:0] thr;
		logic [COUNT_W-1:0] cnt;
		logic [FRAC_W-1:0] frac;
		logic [31:0] nbs;
		logic [3:0] pick;
		cell_in_t c;

		// Rule codes and the special cases, one cell each
		add_row(RULE_NONE, 4'h0, 4'h0, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h0, 16'h0000, 32'h0000_0000, 8'h00, 16'h0000}, 1'b1, 4'h0, 1'b1);
		add_row(RULE_NONE, 4'h0, 4'h0, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'hF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF}, 1'b1, 4'h0, 1'b1);
		add_row(RULE_UNUSED_LO, 4'h3, 4'h9, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h3, 16'h0100, 32'h9999_9999, 8'hFF, 16'h1234}, 1'b1, 4'h0, 1'b1);
		add_row(RULE_UNUSED_HI, 4'h3, 4'h9, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h3, 16'h0100, 32'h9999_9999, 8'hFF, 16'h1234}, 1'b1, 4'h0, 1'b1);
		add_row(RULE_STRAIGHT, 4'h3, 4'h9, 4'h0, 16'd100, 5'd16, 17'd0,
			{4'h3, 16'd100, 32'h0000_0000, 8'hFF, 16'h0000}, 1'b1, 4'h9, 1'b0);
		add_row(RULE_STRAIGHT, 4'h3, 4'h9, 4'h0, 16'd100, 5'd16, 17'd0,
			{4'h3, 16'd99, 32'h0000_0000, 8'hFF, 16'h0000}, 1'b1, 4'h3, 1'b0);
		add_row(RULE_STRAIGHT, 4'h3, 4'h9, 4'h0, 16'd100, 5'd16, 17'd0,
			{4'h4, 16'hFFFF, 32'h0000_0000, 8'hFF, 16'h0000}, 1'b1, 4'h4, 1'b0);
		add_row(RULE_STRAIGHT, 4'hF, 4'h0, 4'h0, 16'hFFFF, 5'd16, 17'd0,
			{4'hF, 16'hFFFF, 32'hFFFF_FFFF, 8'h00, 16'hFFFF}, 1'b1, 4'h0, 1'b0);
		add_row(RULE_STRAIGHT, 4'h0, 4'hF, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h0, 16'h0000, 32'h0000_0000, 8'h00, 16'h0000}, 1'b1, 4'hF, 1'b0);
		add_row(RULE_TRIGGER, 4'h2, 4'h7, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h2, 16'h0000, 32'h1111_1117, 8'h80, 16'h0000}, 1'b0, 4'h0, 1'b0);
		add_row(RULE_TRIGGER, 4'h2, 4'h7, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h2, 16'h0000, 32'h1111_1117, 8'h7F, 16'h0000}, 1'b0, 4'h0, 1'b0);
		add_row(RULE_TRIGGER, 4'h2, 4'h7, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h5, 16'h0000, 32'h7777_7777, 8'hFF, 16'h0000}, 1'b0, 4'h0, 1'b0);
		add_row(RULE_MAJORITY, 4'h0, 4'h0, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h9, 16'h0000, 32'h1122_3344, 8'hFF, 16'h0000}, 1'b0, 4'h0, 1'b0);
		add_row(RULE_MAJORITY, 4'h0, 4'h0, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h9, 16'h0000, 32'h5575_5F05, 8'hFF, 16'h0000}, 1'b0, 4'h0, 1'b0);
		add_row(RULE_MAJORITY, 4'h0, 4'h0, 4'h0, 16'd0, 5'd4, 17'd0,
			{4'hC, 16'h0000, 32'h9999_1AB2, 8'hFF, 16'h0000}, 1'b0, 4'h0, 1'b0);
		add_row(RULE_MAJORITY, 4'h0, 4'h0, 4'h0, 16'd0, 5'd0, 17'd0,
			{4'h6, 16'h0000, 32'h0000_0000, 8'hFF, 16'h0000}, 1'b1, 4'h0, 1'b0);
		add_row(RULE_MAJORITY, 4'h0, 4'h0, 4'h0, 16'd0, 5'd31, 17'd0,
			{4'h6, 16'h0000, 32'hFFFF_FFF1, 8'hFF, 16'h0000}, 1'b0, 4'h0, 1'b0);
		add_row(RULE_MAJORITY, 4'h0, 4'h0, 4'h0, 16'd0, 5'd16, 17'd0,
			{4'h6, 16'h0000, 32'h5555_5555, 8'h00, 16'h0000}, 1'b1, 4'h0, 1'b0);
		add_row(RULE_PROB, 4'h6, 4'hA, 4'hB, 16'd10, 5'd16, 17'h08000,
			{4'h6, 16'd10, 32'h0000_0000, 8'hFF, 16'h7FFF}, 1'b1, 4'hA, 1'b0);
		add_row(RULE_PROB, 4'h6, 4'hA, 4'hB, 16'd10, 5'd16, 17'h08000,
			{4'h6, 16'd10, 32'h0000_0000, 8'hFF, 16'h8000}, 1'b1, 4'hB, 1'b0);
		add_row(RULE_PROB, 4'h6, 4'hA, 4'hB, 16'd10, 5'd16, 17'h08000,
			{4'h6, 16'd9, 32'h0000_0000, 8'hFF, 16'h0000}, 1'b1, 4'h6, 1'b0);
		add_row(RULE_PROB, 4'h6, 4'hA, 4'hB, 16'd10, 5'd16, 17'h10000,
			{4'h6, 16'hFFFF, 32'h0000_0000, 8'hFF, 16'hFFFF}, 1'b1, 4'hA, 1'b0);
		add_row(RULE_PROB, 4'h6, 4'hA, 4'hB, 16'd10, 5'd16, 17'h00000,
			{4'h6, 16'hFFFF, 32'h0000_0000, 8'hFF, 16'h0000}, 1'b1, 4'hB, 1'b0);
		add_row(RULE_PROB, 4'h6, 4'hA, 4'hB, 16'd10, 5'd16, 17'h1FFFF,
			{4'h6, 16'hFFFF, 32'h0000_0000, 8'hFF, 16'hFFFF}, 1'b1, 4'hA, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (dir_rows[i]) begin
			set_rule(dir_rows[i].kind, dir_rows[i].src, dir_rows[i].tgt, dir_rows[i].alt,
				dir_rows[i].thr, dir_rows[i].cnt, dir_rows[i].frac, 1'b0);
			send_cell(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);
			idle_gap();
		end

		// Random phases: every rule code, then the live rules again with fresh settings
		for (int p = 0; p < 16; p++) begin
			kind = (p < 8) ? KIND_W'(p) : KIND_W'(RULE_STRAIGHT + $urandom_range(0, 3));
			case ($urandom_range(0, 3))
				0: thr = '0;
				1: thr = '1;
				2: thr = AGE_W'($urandom_range(0, 300));
				default: thr = AGE_W'($urandom);
			endcase
			case ($urandom_range(0, 5))
				0: cnt = 5'd0;
				1: cnt = 5'd1;
				2: cnt = 5'd16;
				3: cnt = 5'd31;
				4: cnt = COUNT_W'($urandom_range(2, 15));
				default: cnt = COUNT_W'($urandom);
			endcase
			case ($urandom_range(0, 4))
				0: frac = '0;
				1: frac = 17'h10000;
				2: frac = 17'h1FFFF;
				3: frac = FRAC_W'($urandom_range(0, 65535));
				default: frac = FRAC_W'($urandom);
			endcase
			set_rule(kind, TYPE_W'($urandom), TYPE_W'($urandom), TYPE_W'($urandom),
				thr, cnt, frac, 1'b1);

			for (int n = 0; n < 112; n++) begin
				c = cell_in_t'($bits(cell_in_t)'({$urandom, $urandom, $urandom}));
				// bias the center toward the source type
				if ($urandom_range(0, 1))
					c.center_type = cfg_source;
				// ages around the threshold and at the ends
				r = $urandom_range(0, 5);
				if (r < 2) begin
					a = int'(cfg_thresh) + int'($urandom_range(0, 4)) - 2;
					c.center_age = AGE_W'((a < 0) ? 0 : (a > 65535) ? 65535 : a);
				end else if (r == 2) begin
					c.center_age = $urandom_range(0, 1) ? '1 : '0;
				end
				// neighbors from a small pool so triggers and ties show up
				if ($urandom_range(0, 9) != 0) begin
					for (int k = 0; k < MAX_NEIGHBORS; k++) begin
						r = $urandom_range(0, 9);
						pick = (r < 3) ? cfg_target : (r < 7) ? 4'($urandom_range(0, 3)) :
							4'($urandom);
						nbs[31 - 4 * k -: 4] = pick;
					end
					{c.neighbor_type_0, c.neighbor_type_1, c.neighbor_type_2,
						c.neighbor_type_3, c.neighbor_type_4, c.neighbor_type_5,
						c.neighbor_type_6, c.neighbor_type_7} = nbs;
				end
				r = $urandom_range(0, 9);
				if (r < 5)
					c.neighbor_valid = '1;
				else if (r == 5)
					c.neighbor_valid = '0;
				// draws right at the success fraction
				if ($urandom_range(0, 1) && cfg_frac <= 17'h0FFFF) begin
					d = int'(cfg_frac) + int'($urandom_range(0, 2)) - 1;
					c.random_draw = DRAW_W'((d < 0) ? 0 : (d > 65535) ? 65535 : d);
				end
				send_cell(c, 1'b0, '0);
				if (p % 3 != 0)
					idle_gap();
			end
		end

		drain();
		if (fails == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
